[rtl/hkvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkvs_pkg
// Shared constants, command and status codes for the hashed key/value store.
// ----------------------------------------------------------------------------
package hkvs_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int BUCKETS_DEF  = 256;

    localparam logic [31:0] HASH_MULT = 32'd2654435769;

    localparam logic [1:0] CMD_INS = 2'd0;
    localparam logic [1:0] CMD_GET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // count trailing zero bits of a bucket count, capped at 31
    function automatic int tz_bits(input int n);
        int b;
        int v;
        b = 0;
        v = n;
        while (v != 0 && (v % 2) == 0 && b < 31) begin
            v = v / 2;
            b = b + 1;
        end
        return b;
    endfunction

endpackage

[rtl/hashed_key_value_store_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_value_store_core
// Fixed-capacity chained hash table with insert, get and remove commands.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one beat per command; tuser carries the command code,
//   tdata carries key and value. Master channel: one result beat per
//   command; tuser carries the status, tdata the found value and the
//   number of stored entries after the command.
//   Sequence: every command passes the hash, head-read and head states;
//   an insert that appends behind an existing tail adds a link-write
//   state; get/remove then walk the chain through the entry RAMs with
//   registered reads (one address then one compare per entry).
//   One command is in flight at a time; s_axis_tready is high only while
//   the sequencer is idle.
//   Reset: after i_rst_n is released a clearing pass over max(BUCKETS,
//   CAPACITY) addresses empties every bucket head and refills the free stack;
//   no command is taken meanwhile.
//   A stalled receiver holds the result in the output register; the block
//   waits with the next result until that beat is taken.
// ----------------------------------------------------------------------------
module hashed_key_value_store_core #(
    parameter int CAPACITY = hkvs_pkg::CAPACITY_DEF,
    parameter int BUCKETS  = hkvs_pkg::BUCKETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // found_value[31:0], entry_total[40:32], zero
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int IDXW = $clog2(CAPACITY);
    localparam int LNKW = IDXW + 1;
    localparam int BW   = $clog2(BUCKETS);
    localparam int SCW  = $clog2(CAPACITY + 1);
    localparam int MAXN = (BUCKETS > CAPACITY) ? BUCKETS : CAPACITY;
    localparam int CLW  = $clog2(MAXN);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_RDH   = 4'd3;
    localparam logic [3:0] S_HEAD  = 4'd4;
    localparam logic [3:0] S_INS2  = 4'd5;
    localparam logic [3:0] S_FETCH = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]      r_state, n_state;
    logic [CLW-1:0]  r_clr;
    logic [1:0]      r_cmd;
    logic [31:0]     r_key, r_val;
    logic [BW-1:0]   r_bucket;
    logic [IDXW-1:0] r_tail, r_e, r_prev;
    logic            r_prev_ok;
    logic [LNKW-1:0] r_link;
    logic [SCW-1:0]  r_steps, r_free, r_stored;
    logic [1:0]      r_res_st;
    logic [31:0]     r_res_val;
    logic            r_ovalid;
    logic [1:0]      r_ostatus;
    logic [31:0]     r_ofound;
    logic [8:0]      r_ototal;

    logic [BW-1:0]   w_hbucket;
    logic [LNKW-1:0] head_rdata, next_rdata;
    logic [IDXW-1:0] tail_rdata, fs_rdata, w_cur;
    logic [63:0]     kv_rdata;

    logic            head_we, tail_we, next_we, kv_we, fs_we;
    logic [BW-1:0]   head_wa, tail_wa;
    logic [IDXW-1:0] next_wa, kv_wa, fs_wa, tail_wd, fs_wd;
    logic [LNKW-1:0] head_wd, next_wd;
    logic [LNKW-1:0] w_link_m1;

    assign w_link_m1 = r_link - LNKW'(1);
    assign w_cur     = w_link_m1[IDXW-1:0];

    // hash unit
    hkvs_hash #(.BUCKETS(BUCKETS)) u_hash (
        .i_clk    (i_clk),
        .i_en     (r_state == S_HASH),
        .i_key    (r_key),
        .o_bucket (w_hbucket)
    );

    // memories
    hkvs_ram #(.WIDTH(LNKW), .DEPTH(BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(w_hbucket), .o_rdata(head_rdata)
    );
    hkvs_ram #(.WIDTH(IDXW), .DEPTH(BUCKETS)) u_tail (
        .i_clk(i_clk), .i_we(tail_we), .i_waddr(tail_wa), .i_wdata(tail_wd),
        .i_raddr(w_hbucket), .o_rdata(tail_rdata)
    );
    hkvs_ram #(.WIDTH(LNKW), .DEPTH(CAPACITY)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(w_cur), .o_rdata(next_rdata)
    );
    hkvs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_kv (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(kv_wa), .i_wdata({r_key, r_val}),
        .i_raddr(w_cur), .o_rdata(kv_rdata)
    );
    hkvs_ram #(.WIDTH(IDXW), .DEPTH(CAPACITY)) u_free (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_wa), .i_wdata(fs_wd),
        .i_raddr(IDXW'(r_free - SCW'(1))), .o_rdata(fs_rdata)
    );

    // memory write steering
    always_comb begin
        head_we = 1'b0; head_wa = r_bucket; head_wd = '0;
        tail_we = 1'b0; tail_wa = r_bucket; tail_wd = '0;
        next_we = 1'b0; next_wa = '0;       next_wd = '0;
        kv_we   = 1'b0; kv_wa   = fs_rdata;
        fs_we   = 1'b0; fs_wa   = r_free[IDXW-1:0]; fs_wd = w_cur;
        case (r_state)
            S_CLR: begin
                head_we = (32'(r_clr) < BUCKETS);
                head_wa = r_clr[BW-1:0];
                fs_we   = (32'(r_clr) < CAPACITY);
                fs_wa   = r_clr[IDXW-1:0];
                fs_wd   = r_clr[IDXW-1:0];
            end
            S_HEAD: begin
                if (r_cmd == hkvs_pkg::CMD_INS && r_free != '0) begin
                    kv_we   = 1'b1;
                    next_we = 1'b1;
                    next_wa = fs_rdata;
                    next_wd = '0;
                    head_we = (head_rdata == '0);
                    head_wd = LNKW'(fs_rdata) + LNKW'(1);
                    tail_we = 1'b1;
                    tail_wd = fs_rdata;
                end
            end
            S_INS2: begin
                next_we = 1'b1;
                next_wa = r_tail;
                next_wd = LNKW'(r_e) + LNKW'(1);
            end
            S_CMP: begin
                if (r_cmd == hkvs_pkg::CMD_DEL && kv_rdata[63:32] == r_key) begin
                    next_we = r_prev_ok;
                    next_wa = r_prev;
                    next_wd = next_rdata;
                    head_we = !r_prev_ok;
                    head_wd = next_rdata;
                    tail_we = r_prev_ok && (next_rdata == '0);
                    tail_wd = r_prev;
                    fs_we   = (32'(r_free) < CAPACITY);
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   if (r_clr == CLW'(MAXN - 1)) n_state = S_IDLE;
            S_IDLE:  if (s_axis_tvalid) n_state = S_HASH;
            S_HASH:  n_state = S_RDH;
            S_RDH:   n_state = S_HEAD;
            S_HEAD: begin
                if (r_cmd == hkvs_pkg::CMD_INS) begin
                    n_state = (r_free != '0 && head_rdata != '0) ? S_INS2 : S_DONE;
                end else if ((r_cmd == hkvs_pkg::CMD_GET || r_cmd == hkvs_pkg::CMD_DEL)
                             && head_rdata != '0) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS2:  n_state = S_DONE;
            S_FETCH: n_state = S_CMP;
            S_CMP: begin
                if (kv_rdata[63:32] == r_key || next_rdata == '0
                    || 32'(r_steps) + 1 >= CAPACITY) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_DONE:  if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_free   <= SCW'(CAPACITY);
            r_stored <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + CLW'(1);
            end
            // load a finished result, else drop the beat once taken
            if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_HEAD && r_cmd == hkvs_pkg::CMD_INS && r_free != '0) begin
                r_free   <= r_free - SCW'(1);
                r_stored <= r_stored + SCW'(1);
            end
            if (r_state == S_CMP && r_cmd == hkvs_pkg::CMD_DEL
                && kv_rdata[63:32] == r_key) begin
                if (32'(r_free) < CAPACITY) begin
                    r_free <= r_free + SCW'(1);
                end
                if (r_stored != '0) begin
                    r_stored <= r_stored - SCW'(1);
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_cmd <= s_axis_tuser;
            r_key <= s_axis_tdata[31:0];
            r_val <= s_axis_tdata[63:32];
        end
        if (r_state == S_RDH) begin
            r_bucket <= w_hbucket;
        end
        if (r_state == S_HEAD) begin
            r_tail    <= tail_rdata;
            r_e       <= fs_rdata;
            r_link    <= head_rdata;
            r_prev_ok <= 1'b0;
            r_steps   <= '0;
            r_res_val <= '0;
            if (r_cmd == hkvs_pkg::CMD_INS) begin
                r_res_st <= (r_free == '0) ? hkvs_pkg::ST_FULL : hkvs_pkg::ST_OK;
            end else begin
                r_res_st <= hkvs_pkg::ST_MISS;
            end
        end
        // compare one chain entry, advance on a miss
        if (r_state == S_CMP) begin
            if (kv_rdata[63:32] == r_key) begin
                r_res_st  <= hkvs_pkg::ST_OK;
                r_res_val <= kv_rdata[31:0];
            end else begin
                r_prev    <= w_cur;
                r_prev_ok <= 1'b1;
                r_link    <= next_rdata;
                r_steps   <= r_steps + SCW'(1);
            end
        end
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_ostatus <= r_res_st;
            r_ofound  <= r_res_val;
            r_ototal  <= 9'(r_stored);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tdata  = {7'd0, r_ototal, r_ofound};

endmodule

[rtl/hkvs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hkvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/hkvs_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkvs_hash
// Fibonacci hash unit: registered 32x32 multiply, bucket from the top bits.
// ----------------------------------------------------------------------------
module hkvs_hash #(
    parameter int BUCKETS = hkvs_pkg::BUCKETS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [31:0]                i_key,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);

    localparam int BW = $clog2(BUCKETS);
    localparam int HB = hkvs_pkg::tz_bits(BUCKETS);

    logic [31:0] r_prod;
    logic [31:0] w_top;

    // keep the low word of the product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 32'(i_key * hkvs_pkg::HASH_MULT);
        end
    end

    // top HB bits; no trailing zeros selects bucket zero
    assign w_top    = (HB == 0) ? 32'd0 : (r_prod >> (32 - HB));
    assign o_bucket = w_top[BW-1:0];

endmodule

[test/tb_hashed_key_value_store_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_key_value_store_core
// Self-checking bench for the chained hash table: a queue-fed driver sends
// insert, get, remove and unused commands; a scoreboard built on a local
// table model predicts every result beat and the monitor checks it.
// ----------------------------------------------------------------------------
module tb_hashed_key_value_store_core;

    localparam int NCAP = 256;
    localparam int NBKT = 256;
    localparam int LIMIT = 5000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] value;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [8:0]  entry_total;
    } rsp_beat_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    hashed_key_value_store_core dut (.*);

    always #10 i_clk = ~i_clk;

    // table model
    logic [8:0]  tbl_head [NBKT];
    logic [7:0]  tbl_tail [NBKT];
    logic [8:0]  tbl_next [NCAP];
    logic [31:0] tbl_key  [NCAP];
    logic [31:0] tbl_val  [NCAP];
    logic [7:0]  tbl_free [NCAP];
    int          free_cnt;
    int          used_cnt;

    cmd_beat_t pending_cmds[$];
    rsp_beat_t expected_rsps[$];
    int        fails = 0;
    int        n_rsp = 0;
    int        n_full = 0;
    int        n_hit = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off = 0;
    int        cycles = 0;
    logic [31:0] key_pool [16];

    function automatic logic [7:0] bucket_of(logic [31:0] k);
        logic [31:0] p;
        p = k * hkvs_pkg::HASH_MULT;
        return p[31:24];
    endfunction

    function automatic rsp_beat_t apply_cmd(cmd_beat_t c);
        rsp_beat_t r;
        logic [7:0] b;
        logic [8:0] link;
        logic [7:0] e;
        logic [7:0] prev;
        bit have_prev;
        r = '{status: hkvs_pkg::ST_MISS, found_value: 0, entry_total: 0};
        b = bucket_of(c.key);
        if (c.cmd == hkvs_pkg::CMD_INS) begin
            if (free_cnt == 0) begin
                r.status = hkvs_pkg::ST_FULL;
            end else begin
                free_cnt--;
                e = tbl_free[free_cnt];
                tbl_key[e] = c.key;
                tbl_val[e] = c.value;
                tbl_next[e] = 0;
                if (tbl_head[b] == 0) tbl_head[b] = 9'(e) + 9'd1;
                else tbl_next[tbl_tail[b]] = 9'(e) + 9'd1;
                tbl_tail[b] = e;
                used_cnt++;
                r.status = hkvs_pkg::ST_OK;
            end
        end else if (c.cmd == hkvs_pkg::CMD_GET || c.cmd == hkvs_pkg::CMD_DEL) begin
            link = tbl_head[b];
            have_prev = 0;
            prev = 0;
            while (link != 0) begin
                e = 8'(link - 9'd1);
                if (tbl_key[e] == c.key) begin
                    r.found_value = tbl_val[e];
                    r.status = hkvs_pkg::ST_OK;
                    if (c.cmd == hkvs_pkg::CMD_DEL) begin
                        if (have_prev) tbl_next[prev] = tbl_next[e];
                        else tbl_head[b] = tbl_next[e];
                        if (tbl_next[e] == 0 && have_prev) tbl_tail[b] = prev;
                        tbl_free[free_cnt] = e;
                        free_cnt++;
                        used_cnt--;
                    end
                    break;
                end
                prev = e;
                have_prev = 1;
                link = tbl_next[e];
            end
        end
        r.entry_total = used_cnt[8:0];
        return r;
    endfunction

    function automatic cmd_beat_t mk(logic [1:0] c, logic [31:0] k, logic [31:0] v);
        cmd_beat_t x;
        x.cmd = c;
        x.key = k;
        x.value = v;
        return x;
    endfunction

    // driver: present the next queued command, predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_rsps.push_back(apply_cmd(pending_cmds.pop_front()));
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {pending_cmds[0].value, pending_cmds[0].key};
                    s_axis_tuser  <= pending_cmds[0].cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        rsp_beat_t exp_r;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_rsp <= n_rsp + 1;
            if (expected_rsps.size() == 0) begin
                $error("unexpected result beat");
                fails = fails + 1;
            end else begin
                exp_r = expected_rsps.pop_front();
                if (exp_r.status == hkvs_pkg::ST_FULL) n_full <= n_full + 1;
                if (exp_r.status == hkvs_pkg::ST_OK && exp_r.found_value != 0)
                    n_hit <= n_hit + 1;
                if (m_axis_tuser != exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, m_axis_tuser);
                    fails = fails + 1;
                end
                if (m_axis_tdata[31:0] != exp_r.found_value) begin
                    $error("found_value exp %h got %h", exp_r.found_value,
                           m_axis_tdata[31:0]);
                    fails = fails + 1;
                end
                if (m_axis_tdata[40:32] != exp_r.entry_total) begin
                    $error("entry_total exp %0d got %0d", exp_r.entry_total,
                           m_axis_tdata[40:32]);
                    fails = fails + 1;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic drain();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic random_cmds(int n);
        logic [31:0] k;
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 80) k = key_pool[$urandom_range(15)];
            else k = $urandom;
            r = $urandom_range(99);
            if (r < 45) pending_cmds.push_back(mk(hkvs_pkg::CMD_INS, k, $urandom));
            else if (r < 70) pending_cmds.push_back(mk(hkvs_pkg::CMD_GET, k, $urandom));
            else if (r < 97) pending_cmds.push_back(mk(hkvs_pkg::CMD_DEL, k, $urandom));
            else pending_cmds.push_back(mk(CMD_UNUSED, k, $urandom));
        end
    endtask

    initial begin
        logic [31:0] ck [3];
        logic [31:0] kk;
        int          nck;
        for (int i = 0; i < NBKT; i++) begin
            tbl_head[i] = 0;
            tbl_tail[i] = 0;
        end
        for (int i = 0; i < NCAP; i++) begin
            tbl_next[i] = 0;
            tbl_key[i] = 0;
            tbl_val[i] = 0;
            tbl_free[i] = 8'(i);
        end
        free_cnt = NCAP;
        used_cnt = 0;
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;

        // find three keys that share the bucket of key zero
        nck = 0;
        kk = 32'd1;
        while (nck < 3) begin
            if (bucket_of(kk) == bucket_of(32'h0)) begin
                ck[nck] = kk;
                nck++;
            end
            kk = kk + 32'd1;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicates, misses, unused code
        pending_cmds.push_back(mk(hkvs_pkg::CMD_GET, 32'h0, 32'h0));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_DEL, 32'hFFFF_FFFF, 32'h0));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_INS, 32'h0, 32'hFFFF_FFFF));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_INS, 32'hFFFF_FFFF, 32'h0000_0001));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_INS, 32'h0, 32'hA5A5_5A5A));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_GET, 32'h0, 32'h0));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_cmds.push_back(mk(CMD_UNUSED, 32'h0, 32'hFFFF_FFFF));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_DEL, 32'h0, 32'h0));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_GET, 32'h0, 32'h0));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_DEL, 32'h0, 32'h0));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_DEL, 32'h0, 32'h0));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_GET, 32'h1234_5678, 32'h0));
        // key 0 and the found keys collide in one bucket: unlink middle and tail
        pending_cmds.push_back(mk(hkvs_pkg::CMD_INS, 32'h0, 32'h11));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_INS, ck[0], 32'h22));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_INS, ck[1], 32'h33));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_DEL, ck[1], 32'h0));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_INS, ck[2], 32'h44));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_DEL, ck[0], 32'h0));
        pending_cmds.push_back(mk(hkvs_pkg::CMD_GET, ck[2], 32'h0));
        drain();

        // fill past capacity to hit table full, then empty it
        for (int i = 0; i < NCAP + 3; i++)
            pending_cmds.push_back(mk(hkvs_pkg::CMD_INS, $urandom, $urandom));
        drain();
        for (int i = 0; i < NCAP; i++)
            pending_cmds.push_back(mk(hkvs_pkg::CMD_DEL, tbl_key[i], 32'h0));
        drain();

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 77 : 15) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 77 : 15) : 0;
            if (ph == 2) hold_off = 3000;
            random_cmds(250);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_cmds(100);
        drain();

        repeat (50) @(posedge i_clk);
        $display("Covered %0d results: %0d hits, %0d table-full answers,", n_rsp, n_hit,
                 n_full);
        $display("with collisions, duplicates, overflow and backpressure phases.");
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
